// ----- sv/priority_ready_queue_defines.svh -----
// Assertion macros for the ready queue
`ifndef PRIORITY_READY_QUEUE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PRQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("priority_ready_queue: same-cycle check failed");

// next-cycle implication, checked outside reset
`define PRQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("priority_ready_queue: next-cycle check failed");

`endif

// ----- sv/prq_pkg.sv -----
package prq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = 4;   // index into the cell row
    localparam int CNT_W       = 5;   // holds 0..QUEUE_DEPTH
    localparam int MAX_CPUS    = 8;
    localparam int CPU_W       = 4;   // width of the cpu_count register
    localparam int DISP_W      = 3;   // index of a result within one dispatch

    localparam int ID_W  = 16;
    localparam int PRI_W = 3;

    // priority limits
    localparam logic [PRI_W-1:0] PRI_FALLBACK = 3'd1;
    localparam logic [PRI_W-1:0] PRI_RANGE_LO = 3'd1;
    localparam logic [PRI_W-1:0] PRI_RANGE_HI = 3'd4;

    // operation codes
    localparam logic [1:0] FUNC_INSERT   = 2'd0;
    localparam logic [1:0] FUNC_REMOVE   = 2'd1;
    localparam logic [1:0] FUNC_DISPATCH = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_DISP
    } prq_state_t;

    // one queue entry as held by a cell
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } prq_entry_t;

    // command broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [ID_W-1:0]  key;
        logic [PRI_W-1:0] pri;
    } prq_cmd_t;

    // raw request priority to stored priority; out of range maps to default
    function automatic logic [PRI_W-1:0] prq_norm_pri(input logic [3:0] raw);
        logic [PRI_W-1:0] p;
        if ((raw >= {1'b0, PRI_RANGE_LO}) && (raw <= {1'b0, PRI_RANGE_HI}))
        begin
            p = raw[PRI_W-1:0];
        end
        else
        begin
            p = PRI_FALLBACK;
        end
        return p;
    endfunction

endpackage

// ----- sv/priority_ready_queue.sv -----
// Ready queue of up to 16 jobs kept sorted by priority (1 first, 4 last; equal
// priorities stay in arrival order), held in a row of cells that all update in
// the same clock edge. Insert and remove each update the cell row when taken;
// their single result sits in the output register, and the next item is taken
// once that register is empty or being drained, so while results are taken as
// they come a stream of them runs at one item a cycle. Dispatch gives n =
// min(cpu_count, entries) results, one result a cycle while they are taken,
// read from the head cells through a mux; an empty queue gives one result with
// status empty. cpu_count of 0 acts as 1 and values above 8 act as 8. Write
// cpu_count only while the block is idle.
`include "priority_ready_queue_defines.svh"

module priority_ready_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    // input items
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic [15:0]                  job_id,
    input  logic [3:0]                   priority_req,
    // result items
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [15:0]                  entry_id,
    output logic [2:0]                   entry_priority,
    output logic [4:0]                   queue_count,
    output logic                         last,
    // cpu_count register
    input  logic                         cfg_we,
    input  logic [prq_pkg::CPU_W-1:0]    cfg_wdata
);
    import prq_pkg::*;

    prq_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CPU_W-1:0]    cpu_reg;
    logic [DISP_W-1:0]   disp_idx_reg, disp_idx_next;
    logic [DISP_W-1:0]   disp_last_reg, disp_last_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          status_reg, status_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [PRI_W-1:0]    pri_reg, pri_next;
    logic [CNT_W-1:0]    qcnt_reg, qcnt_next;
    logic                last_reg, last_next;

    logic                in_fire;
    logic                out_free;
    logic                full;
    logic                found;
    logic [PRI_W-1:0]    norm_pri;
    logic [CPU_W-1:0]    cpus_eff;
    logic [CPU_W-1:0]    n_disp;
    prq_cmd_t            cmd;
    prq_entry_t          rd_data;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign norm_pri = prq_norm_pri(priority_req);

    // clamp cpu_count to 1..MAX_CPUS, then limit by the fill level
    always_comb
    begin
        cpus_eff = cpu_reg;
        if (cpu_reg == '0)
        begin
            cpus_eff = CPU_W'(1);
        end
        else if (cpu_reg > CPU_W'(MAX_CPUS))
        begin
            cpus_eff = CPU_W'(MAX_CPUS);
        end
        n_disp = ({1'b0, cpus_eff} < count_reg) ? cpus_eff : count_reg[CPU_W-1:0];
    end

    // command to the cell row
    always_comb
    begin
        cmd.ins = in_fire && (func == FUNC_INSERT) && !full;
        cmd.rem = in_fire && (func == FUNC_REMOVE);
        cmd.key = job_id;
        cmd.pri = norm_pri;
    end

    prq_chain u_chain (
        .clk     (clk),
        .cmd     (cmd),
        .count   (count_reg),
        .rd_idx  (IDX_W'(disp_idx_reg)),
        .found   (found),
        .rd_data (rd_data)
    );

    // control and result register load
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        disp_idx_next  = disp_idx_reg;
        disp_last_next = disp_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        id_next        = id_reg;
        pri_next       = pri_reg;
        qcnt_next      = qcnt_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (func)
                        FUNC_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            last_next      = 1'b1;
                            id_next        = job_id;
                            if (full)
                            begin
                                status_next = STAT_FULL;
                                pri_next    = '0;
                                qcnt_next   = count_reg;
                            end
                            else
                            begin
                                count_next  = count_reg + CNT_W'(1);
                                status_next = STAT_OK;
                                pri_next    = norm_pri;
                                qcnt_next   = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            out_valid_next = 1'b1;
                            last_next      = 1'b1;
                            id_next        = job_id;
                            pri_next       = '0;
                            if (found)
                            begin
                                count_next  = count_reg - CNT_W'(1);
                                status_next = STAT_OK;
                                qcnt_next   = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_next = STAT_NOT_FOUND;
                                qcnt_next   = count_reg;
                            end
                        end
                        FUNC_DISPATCH:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                last_next      = 1'b1;
                                status_next    = STAT_EMPTY;
                                id_next        = '0;
                                pri_next       = '0;
                                qcnt_next      = '0;
                            end
                            else
                            begin
                                state_next     = ST_DISP;
                                disp_idx_next  = '0;
                                disp_last_next = DISP_W'(n_disp - CPU_W'(1));
                            end
                        end
                        default:
                        begin
                            // unused code: no result, no change
                        end
                    endcase
                end
            end
            ST_DISP:
            begin
                // one head entry per free output slot
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    id_next        = rd_data.id;
                    pri_next       = rd_data.pri;
                    qcnt_next      = count_reg;
                    last_next      = (disp_idx_reg == disp_last_reg);
                    disp_idx_next  = disp_idx_reg + DISP_W'(1);
                    if (disp_idx_reg == disp_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cpu_reg       <= CPU_W'(1);
            out_valid_reg <= 1'b0;
            disp_idx_reg  <= '0;
            disp_last_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            disp_idx_reg  <= disp_idx_next;
            disp_last_reg <= disp_last_next;
            if (cfg_we)
            begin
                cpu_reg <= cfg_wdata;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        id_reg     <= id_next;
        pri_reg    <= pri_next;
        qcnt_reg   <= qcnt_next;
        last_reg   <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign entry_id       = id_reg;
    assign entry_priority = pri_reg;
    assign queue_count    = qcnt_reg;
    assign last           = last_reg;

    // checks
    `PRQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `PRQ_ASSERT_NOW(a_disp_nonempty, state_reg == ST_DISP, count_reg != '0)
    `PRQ_ASSERT_NOW(a_disp_idx, state_reg == ST_DISP, disp_idx_reg <= disp_last_reg)
    `PRQ_ASSERT_NEXT(a_insert_grows, cmd.ins, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

// ----- sv/prq_cell.sv -----
module prq_cell (
    input  logic              clk,
    input  prq_pkg::prq_cmd_t cmd,
    input  logic              occ,        // this cell holds a live entry
    input  prq_pkg::prq_entry_t left_data,
    input  prq_pkg::prq_entry_t right_data,
    input  logic              gt_in,      // left neighbor shifts right on insert
    input  logic              seen_in,    // key matched at or left of left neighbor
    output logic              gt_out,
    output logic              seen_out,
    output prq_pkg::prq_entry_t data
);
    import prq_pkg::*;

    prq_entry_t data_reg;
    prq_entry_t data_next;
    logic       match;

    // local compares
    assign gt_out   = occ && (data_reg.pri > cmd.pri);
    assign match    = occ && (data_reg.id == cmd.key);
    assign seen_out = seen_in || match;

    // insert shifts right behind the slot, remove closes the gap from the right
    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (gt_in)
            begin
                data_next = left_data;
            end
            else if (gt_out || !occ)
            begin
                data_next.id  = cmd.key;
                data_next.pri = cmd.pri;
            end
        end
        else if (cmd.rem && seen_out)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- sv/prq_chain.sv -----
module prq_chain (
    input  logic                            clk,
    input  prq_pkg::prq_cmd_t               cmd,
    input  logic [prq_pkg::CNT_W-1:0]       count,
    input  logic [prq_pkg::IDX_W-1:0]       rd_idx,
    output logic                            found,
    output prq_pkg::prq_entry_t             rd_data
);
    import prq_pkg::*;

    prq_entry_t cell_data [QUEUE_DEPTH];
    logic       gt_chain  [QUEUE_DEPTH+1];
    logic       seen_chain[QUEUE_DEPTH+1];
    logic       gt_out    [QUEUE_DEPTH];

    assign gt_chain[0]   = 1'b0;
    assign seen_chain[0] = 1'b0;

    // row of cells, head at index 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        prq_entry_t left_d;
        prq_entry_t right_d;

        if (i == 0)
        begin : g_head
            assign left_d = cell_data[0];
        end
        else
        begin : g_mid
            assign left_d = cell_data[i-1];
        end

        if (i == QUEUE_DEPTH-1)
        begin : g_tail
            assign right_d = cell_data[i];
        end
        else
        begin : g_body
            assign right_d = cell_data[i+1];
        end

        prq_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .occ        (count > CNT_W'(i)),
            .left_data  (left_d),
            .right_data (right_d),
            .gt_in      (gt_chain[i]),
            .seen_in    (seen_chain[i]),
            .gt_out     (gt_out[i]),
            .seen_out   (seen_chain[i+1]),
            .data       (cell_data[i])
        );

        assign gt_chain[i+1] = gt_out[i];
    end

    assign found   = seen_chain[QUEUE_DEPTH];
    assign rd_data = cell_data[rd_idx];

endmodule
